@@ src/hgsd_pkg.sv @@
// Shared constants, codes and interface types of the hash-gated stream decrypt block.
`default_nettype none

package hgsd_pkg;

  localparam int PAYLOAD_DEPTH = 4096;
  localparam int ADDR_W        = $clog2(PAYLOAD_DEPTH);
  localparam int CNT_W         = $clog2(PAYLOAD_DEPTH + 1);

  localparam logic [63:0] MIX_MUL_A = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_MUL_B = 64'hc4ceb9fe1a85ec53;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_GATE  = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  localparam logic [2:0] CFG_HASH_SEED     = 3'd0;
  localparam logic [2:0] CFG_EXPECTED_HASH = 3'd1;
  localparam logic [2:0] CFG_KEY_MASK      = 3'd2;
  localparam logic [2:0] CFG_STREAM_ADD    = 3'd3;
  localparam logic [2:0] CFG_STREAM_MUL    = 3'd4;
  localparam logic [2:0] CFG_STREAM_XOR    = 3'd5;

  typedef struct packed {
    logic        start;
    logic [63:0] hash;
    logic [7:0]  data;
  } mix_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] hash;
  } mix_rsp_t;

endpackage

`default_nettype wire

@@ src/hash_gated_stream_decrypt_top.sv @@
// Top level of the hash-gated stream decrypt block: payload memory, control and keystream.
//
// Input transactions carry an operation in in_tuser (load, read, clear, no-op) and the
// ciphertext byte and read index in in_tdata. Every input transaction yields exactly one
// output transaction with the plaintext byte, a status code, the gate flag and the number
// of bytes held. Registers are written over the cfg_ channel, which is always ready; they
// may only change while no transaction is in flight.
// A load passes from acceptance through the hash fold to the result register: the fold
// runs two 64-bit multiplies through one 32x32 multiplier. A read steps through payload
// memory read and index product, key add and keystream mix. Clear, no-op and the
// rejected cases (store full, index out of range) skip these steps. A new item is accepted
// once the previous one has reached the output register, even if that result still waits.
// Reset empties the store, zeroes the hash, restores the register defaults and drops
// out_tvalid. The payload memory is not cleared; only entries below the byte count are
// ever read. When out_tready is low the finished result holds and the next item waits in
// its last step until the output register frees up.
`default_nettype none

module hash_gated_stream_decrypt_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [7:0] data_byte, [19:8] byte_index, [23:20] zero
  input  wire logic [1:0]  in_tuser,   // [1:0] operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [7:0] data_out, [20:8] bytes_held, [23:21] zero
  output logic [2:0]       out_tuser,  // [1:0] status, [2] gate_ok
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  import hgsd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HASH = 5'b00010,
    S_RD1  = 5'b00100,
    S_RD2  = 5'b01000,
    S_PUT  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [63:0]       hash_r, hash_nxt;
  logic [63:0]       seed_r, expected_r, key_mask_r;
  logic [31:0]       stream_add_r, stream_mul_r;
  logic [7:0]        stream_xor_r;
  logic [43:0]       prod_r, prod_nxt;
  logic [47:0]       ks_x_r, ks_x_nxt;
  logic [7:0]        pend_data_r, pend_data_nxt;
  status_t           pend_status_r, pend_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_data_r, out_data_nxt;
  status_t           out_status_r, out_status_nxt;
  logic              out_gate_r, out_gate_nxt;
  logic [12:0]       out_held_r, out_held_nxt;

  logic [7:0]        payload_mem [PAYLOAD_DEPTH];
  logic [7:0]        rd_data_r;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] rd_addr;

  mix_req_t          mix_req;
  mix_rsp_t          mix_rsp;

  op_t               in_op;
  logic [7:0]        in_data;
  logic [11:0]       in_idx;
  logic              in_acc;
  logic              store_full;
  logic              gate_match;
  logic [7:0]        ks_byte;

  assign in_op      = op_t'(in_tuser);
  assign in_data    = in_tdata[7:0];
  assign in_idx     = in_tdata[19:8];
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign store_full = (count_r == CNT_W'(PAYLOAD_DEPTH));
  assign gate_match = (hash_r == expected_r);
  assign rd_addr    = ADDR_W'(in_idx);

  // Only the low byte of x ^= x >> 11; x ^= x >> 29 is needed, which folds to four taps.
  assign ks_byte = ks_x_r[7:0] ^ ks_x_r[18:11] ^ ks_x_r[36:29] ^ ks_x_r[47:40] ^ stream_xor_r;

  hgsd_mix u_mix (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mix_req),
    .rsp   (mix_rsp)
  );

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    hash_nxt        = hash_r;
    prod_nxt        = prod_r;
    ks_x_nxt        = ks_x_r;
    pend_data_nxt   = pend_data_r;
    pend_status_nxt = pend_status_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    out_status_nxt  = out_status_r;
    out_gate_nxt    = out_gate_r;
    out_held_nxt    = out_held_r;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    mix_req.start   = 1'b0;
    mix_req.hash    = (count_r == '0) ? seed_r : hash_r;
    mix_req.data    = in_data;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          pend_data_nxt   = 8'd0;
          pend_status_nxt = ST_OK;
          state_nxt       = S_PUT;
          case (in_op)
            OP_LOAD: begin
              if (store_full) begin
                pend_status_nxt = ST_FULL;
              end else begin
                mem_we        = 1'b1;
                mix_req.start = 1'b1;
                state_nxt     = S_HASH;
              end
            end
            OP_READ: begin
              if (32'(in_idx) >= 32'(count_r)) begin
                pend_status_nxt = ST_RANGE;
              end else begin
                mem_re    = 1'b1;
                prod_nxt  = 44'(in_idx) * 44'(stream_mul_r);
                state_nxt = S_RD1;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
              hash_nxt  = '0;
            end
            default: ;
          endcase
        end
      end
      S_HASH: begin
        if (mix_rsp.done) begin
          hash_nxt  = mix_rsp.hash;
          count_nxt = count_r + CNT_W'(1);
          state_nxt = S_PUT;
        end
      end
      S_RD1: begin
        ks_x_nxt  = 48'((hash_r ^ key_mask_r) + 64'(stream_add_r) + 64'(prod_r));
        state_nxt = S_RD2;
      end
      S_RD2: begin
        pend_data_nxt   = rd_data_r ^ ks_byte;
        pend_status_nxt = gate_match ? ST_OK : ST_GATE;
        state_nxt       = S_PUT;
      end
      S_PUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = pend_data_r;
          out_status_nxt = pend_status_r;
          out_gate_nxt   = gate_match;
          out_held_nxt   = 13'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      hash_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      hash_r      <= hash_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r        <= prod_nxt;
    ks_x_r        <= ks_x_nxt;
    pend_data_r   <= pend_data_nxt;
    pend_status_r <= pend_status_nxt;
    out_data_r    <= out_data_nxt;
    out_status_r  <= out_status_nxt;
    out_gate_r    <= out_gate_nxt;
    out_held_r    <= out_held_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r       <= '0;
      expected_r   <= '0;
      key_mask_r   <= '0;
      stream_add_r <= '0;
      stream_mul_r <= 32'd1;
      stream_xor_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HASH_SEED:     seed_r       <= cfg_data;
        CFG_EXPECTED_HASH: expected_r   <= cfg_data;
        CFG_KEY_MASK:      key_mask_r   <= cfg_data;
        CFG_STREAM_ADD:    stream_add_r <= cfg_data[31:0];
        CFG_STREAM_MUL:    stream_mul_r <= cfg_data[31:0];
        CFG_STREAM_XOR:    stream_xor_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      payload_mem[count_r[ADDR_W-1:0]] <= in_data;
    end
    if (mem_re) begin
      rd_data_r <= payload_mem[rd_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_held_r, out_data_r};
  assign out_tuser  = {out_gate_r, out_status_r};

endmodule

`default_nettype wire

@@ src/hgsd_mix.sv @@
// Byte fold of the running hash, two 64-bit multiplies built from one shared 32x32 multiplier.
`default_nettype none

module hgsd_mix (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire hgsd_pkg::mix_req_t req,
  output hgsd_pkg::mix_rsp_t    rsp
);
  import hgsd_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [63:0] k;
  logic [31:0] mul_a, mul_b;
  logic [31:0] hi_sum;
  logic [63:0] full;

  // Step bit 2 selects the multiplier constant. Within a multiply the low product
  // and two cross products are taken one per cycle; the high-by-high product falls
  // outside 64 bits and is never formed.
  always_comb begin
    k = step_r[2] ? MIX_MUL_B : MIX_MUL_A;
    case (step_r[1:0])
      2'd0: begin
        mul_a = x_r[31:0];
        mul_b = k[31:0];
      end
      2'd1: begin
        mul_a = x_r[31:0];
        mul_b = k[63:32];
      end
      default: begin
        mul_a = x_r[63:32];
        mul_b = k[31:0];
      end
    endcase
    prod_nxt = 64'(mul_a) * 64'(mul_b);
    hi_sum   = acc_r[63:32] + prod_r[31:0];
    full     = {hi_sum, acc_r[31:0]};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    x_nxt    = x_r;
    acc_nxt  = acc_r;

    if (req.start) begin
      x_nxt    = req.hash ^ {56'd0, req.data};
      step_nxt = 3'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      step_nxt = step_r + 3'd1;
      case (step_r[1:0])
        2'd1: acc_nxt = prod_r;
        2'd2: acc_nxt = full;
        2'd3: begin
          if (!step_r[2]) begin
            x_nxt = full ^ (full >> 32);
          end else begin
            x_nxt    = full ^ (full >> 29);
            busy_nxt = 1'b0;
            done_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.hash = x_r;

endmodule

`default_nettype wire

@@ src/hgsd_checker.sv @@
// Port-level checks of the hash-gated stream decrypt block, bound to its top level.
`default_nettype none

module hgsd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic [2:0]  out_tuser
);
  import hgsd_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output transaction valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output transaction changed");

  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == ST_RANGE |-> out_tdata[7:0] == 8'd0)
    else $error("out-of-range read returned data");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == ST_FULL |-> out_tdata[20:8] == 13'(PAYLOAD_DEPTH))
    else $error("store-full status with store not full");

  a_gate_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == ST_GATE |-> !out_tuser[2])
    else $error("gate failure reported while gate flag set");

endmodule

bind hash_gated_stream_decrypt_top hgsd_checker u_hgsd_checker (.*);

`default_nettype wire

@@ sim/tb_hash_gated_stream_decrypt_top.sv @@
// Self-checking testbench of the hash-gated stream decrypt block with its own behavioral predictor.
`default_nettype none

module tb_hash_gated_stream_decrypt_top;
  import hgsd_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int HOLD_CYCLES    = 400;
  localparam int LONG_LOADS     = 200;
  localparam int RANDOM_ITEMS   = 1080;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_RANDOM,
    RX_THIRD,
    RX_DUTY
  } rx_mode_t;

  typedef struct {
    logic [7:0]  data_out;
    status_t     status;
    logic        gate_ok;
    logic [12:0] bytes_held;
  } decrypt_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // Predictor state: payload bytes, fill level, running hash and register copies.
  logic [7:0]  shadow_store [PAYLOAD_DEPTH];
  int          shadow_held;
  logic [63:0] shadow_hash;
  logic [63:0] seed_reg;
  logic [63:0] expected_reg;
  logic [63:0] mask_reg;
  logic [31:0] add_reg;
  logic [31:0] mul_reg;
  logic [7:0]  xor_reg;

  decrypt_result_t pending_results [$];
  logic [7:0]      load_plan [$];

  int       mismatch_count = 0;
  int       burst_left = 0;
  int       idle_cycles = 0;
  int       hold_req = 0;
  int       hold_left = 0;
  int       mode_left = 0;
  int       rx_phase = 0;
  rx_mode_t rx_mode = RX_FREE;

  hash_gated_stream_decrypt_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] fold_hash(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    x = x * MIX_MUL_A;
    x = x ^ (x >> 32);
    x = x * MIX_MUL_B;
    x = x ^ (x >> 29);
    return x;
  endfunction

  function automatic logic [7:0] keystream_byte(input logic [11:0] idx, input logic [63:0] key);
    logic [63:0] x;
    x = key + {32'd0, add_reg} + ({52'd0, idx} * {32'd0, mul_reg});
    x = x ^ (x >> 11);
    x = x ^ (x >> 29);
    return x[7:0] ^ xor_reg;
  endfunction

  // Hash the store reaches after the bytes in load_plan, optionally starting from a clear.
  function automatic logic [63:0] hash_after_loads(input bit from_empty);
    logic [63:0] h;
    int          c;
    h = from_empty ? 64'd0 : shadow_hash;
    c = from_empty ? 0 : shadow_held;
    foreach (load_plan[i]) begin
      if (c < PAYLOAD_DEPTH) begin
        h = fold_hash((c == 0) ? seed_reg : h, load_plan[i]);
        c++;
      end
    end
    return h;
  endfunction

  function automatic logic [63:0] rand_reg_value();
    int roll;
    roll = $urandom_range(0, 5);
    if (roll == 0) return 64'd0;
    if (roll == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic predict_decrypt(input op_t op, input logic [7:0] data, input logic [11:0] idx);
    decrypt_result_t r;
    logic [63:0]     h;
    r.data_out = 8'd0;
    r.status   = ST_OK;
    case (op)
      OP_LOAD: begin
        if (shadow_held >= PAYLOAD_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          h = (shadow_held == 0) ? seed_reg : shadow_hash;
          shadow_store[shadow_held] = data;
          shadow_hash = fold_hash(h, data);
          shadow_held++;
        end
      end
      OP_READ: begin
        if (int'(idx) >= shadow_held) begin
          r.status = ST_RANGE;
        end else begin
          r.data_out = shadow_store[idx] ^ keystream_byte(idx, shadow_hash ^ mask_reg);
          r.status   = (shadow_hash == expected_reg) ? ST_OK : ST_GATE;
        end
      end
      OP_CLEAR: begin
        shadow_held = 0;
        shadow_hash = 64'd0;
      end
      default: ;
    endcase
    r.gate_ok    = (shadow_hash == expected_reg);
    r.bytes_held = shadow_held[12:0];
    pending_results = {pending_results, r};
  endtask

  // Offers one item in bursts with random gaps and returns at the edge that accepts it.
  task automatic send_item(input op_t op, input logic [7:0] data, input logic [11:0] idx);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(8, 24);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'd0, idx, data};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    predict_decrypt(op, data, idx);
    burst_left--;
  endtask

  task automatic send_read();
    logic [11:0] idx;
    int          roll;
    roll = $urandom_range(0, 19);
    if (roll < 15 && shadow_held > 0)
      idx = 12'($urandom_range(0, shadow_held - 1));
    else if (roll < 18)
      idx = 12'((shadow_held + $urandom_range(0, 3) > 4095) ? 4095
                                                           : shadow_held + $urandom_range(0, 3));
    else
      idx = 12'($urandom);
    send_item(OP_READ, 8'($urandom), idx);
  endtask

  task automatic send_noise();
    send_item(op_t'($urandom_range(0, 3)), 8'($urandom), 12'($urandom));
  endtask

  // Stops offering and lets every outstanding result arrive, then lets the block settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_HASH_SEED:     seed_reg = value;
      CFG_EXPECTED_HASH: expected_reg = value;
      CFG_KEY_MASK:      mask_reg = value;
      CFG_STREAM_ADD:    add_reg = value[31:0];
      CFG_STREAM_MUL:    mul_reg = value[31:0];
      CFG_STREAM_XOR:    xor_reg = value[7:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_all_regs(input logic [63:0] value);
    write_reg(CFG_HASH_SEED, value);
    write_reg(CFG_EXPECTED_HASH, value);
    write_reg(CFG_KEY_MASK, value);
    write_reg(CFG_STREAM_ADD, value);
    write_reg(CFG_STREAM_MUL, value);
    write_reg(CFG_STREAM_XOR, value);
  endtask

  task automatic randomize_config();
    if ($urandom_range(0, 1)) write_reg(CFG_HASH_SEED, rand_reg_value());
    if ($urandom_range(0, 1)) write_reg(CFG_KEY_MASK, rand_reg_value());
    if ($urandom_range(0, 1)) write_reg(CFG_STREAM_ADD, rand_reg_value());
    if ($urandom_range(0, 1)) write_reg(CFG_STREAM_MUL, rand_reg_value());
    if ($urandom_range(0, 1)) write_reg(CFG_STREAM_XOR, rand_reg_value());
  endtask

  // Register defaults, empty-store reads, a no-op, two loads, a clear and the byte extremes.
  task automatic test_reset_defaults();
    send_item(OP_NOP, 8'hff, 12'hfff);
    send_item(OP_READ, 8'h00, 12'd0);
    send_item(OP_READ, 8'hff, 12'hfff);
    send_item(OP_LOAD, 8'h00, 12'hfff);
    send_item(OP_LOAD, 8'hff, 12'h000);
    send_item(OP_READ, 8'h00, 12'd0);
    send_item(OP_READ, 8'h00, 12'd1);
    send_item(OP_READ, 8'h00, 12'd2);
    send_item(OP_CLEAR, 8'hff, 12'hfff);
    send_item(OP_READ, 8'h00, 12'd0);
    wait_idle();
  endtask

  // A payload whose hash matches passes the gate; all registers at both extremes.
  task automatic test_gate_pass();
    write_all_regs('1);
    load_plan = '{8'h00, 8'hff, 8'h5a, 8'ha5};
    write_reg(CFG_EXPECTED_HASH, hash_after_loads(1'b1));
    send_item(OP_CLEAR, 8'h00, 12'd0);
    foreach (load_plan[i]) send_item(OP_LOAD, load_plan[i], 12'($urandom));
    for (int i = 0; i < 5; i++) send_item(OP_READ, 8'h00, 12'(i));
    send_item(OP_READ, 8'h00, 12'hfff);
    wait_idle();
    write_all_regs(64'd0);
    send_item(OP_CLEAR, 8'h00, 12'd0);
    send_item(OP_READ, 8'h00, 12'd0);
    send_item(OP_LOAD, 8'h3c, 12'd0);
    send_item(OP_READ, 8'h00, 12'd0);
    wait_idle();
  endtask

  // Loads a long payload, then reads its first and last bytes and just past the end.
  task automatic test_long_payload();
    randomize_config();
    load_plan.delete();
    repeat (LONG_LOADS) load_plan = {load_plan, 8'($urandom)};
    write_reg(CFG_EXPECTED_HASH, hash_after_loads(1'b1));
    send_item(OP_CLEAR, 8'h00, 12'd0);
    foreach (load_plan[i]) send_item(OP_LOAD, load_plan[i], 12'($urandom));
    send_item(OP_READ, 8'h00, 12'(LONG_LOADS - 1));
    send_item(OP_READ, 8'h00, 12'(LONG_LOADS));
    send_item(OP_READ, 8'h00, 12'hfff);
    send_item(OP_READ, 8'h00, 12'd0);
    send_read();
    send_item(OP_CLEAR, 8'h00, 12'd0);
    wait_idle();
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_backpressure();
    hold_req = HOLD_CYCLES;
    send_item(OP_CLEAR, 8'($urandom), 12'($urandom));
    repeat (40) begin
      if ($urandom_range(0, 2) == 0) send_read();
      else send_item(OP_LOAD, 8'($urandom), 12'($urandom));
    end
    wait_idle();
  endtask

  // Phases of clear, loads and reads with random content, with noise mixed in.
  task automatic test_random_phases(input int n_items);
    int sent;
    int n_loads;
    int roll;
    bit do_clear;
    sent = 0;
    while (sent < n_items) begin
      wait_idle();
      randomize_config();
      do_clear = ($urandom_range(0, 4) != 0);
      n_loads = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
      load_plan.delete();
      repeat (n_loads) load_plan = {load_plan, 8'($urandom)};
      roll = $urandom_range(0, 9);
      if (roll < 7) write_reg(CFG_EXPECTED_HASH, hash_after_loads(do_clear));
      else if (roll == 7) write_reg(CFG_EXPECTED_HASH, 64'd0);
      else write_reg(CFG_EXPECTED_HASH, {$urandom, $urandom});
      if (do_clear) begin
        send_item(OP_CLEAR, 8'($urandom), 12'($urandom));
        sent++;
      end
      foreach (load_plan[i]) begin
        send_item(OP_LOAD, load_plan[i], 12'($urandom));
        sent++;
        if ($urandom_range(0, 5) == 0) begin
          send_read();
          sent++;
        end
        if ($urandom_range(0, 19) == 0) begin
          send_noise();
          sent++;
        end
      end
      repeat ($urandom_range(1, 8)) begin
        send_read();
        sent++;
      end
    end
    wait_idle();
  endtask

  // Receiver: changes its ready pattern at random intervals, or holds off on request.
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      rx_phase++;
      case (rx_mode)
        RX_FREE:   out_tready <= 1'b1;
        RX_RANDOM: out_tready <= 1'($urandom_range(0, 1));
        RX_THIRD:  out_tready <= (rx_phase % 3 == 0);
        default:   out_tready <= (rx_phase % 8 < 5);
      endcase
    end
  end

  // Compares each output transaction with the oldest prediction.
  always @(posedge clk) begin
    decrypt_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: data_out %02h status %0d gate_ok %0d bytes_held %0d",
                   out_tdata[7:0], out_tuser[1:0], out_tuser[2], out_tdata[20:8]);
      end else begin
        want = pending_results.pop_front();
        if (want.data_out != out_tdata[7:0] || want.status != out_tuser[1:0] ||
            want.gate_ok != out_tuser[2] || want.bytes_held != out_tdata[20:8]) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected data_out %02h status %0d gate_ok %0d bytes_held %0d, %s",
                     want.data_out, want.status, want.gate_ok, want.bytes_held,
                     $sformatf("got data_out %02h status %0d gate_ok %0d bytes_held %0d",
                               out_tdata[7:0], out_tuser[1:0], out_tuser[2], out_tdata[20:8]));
        end
      end
    end
  end

  // Ends the run when no transaction of any channel completes for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_hash_gated_stream_decrypt_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    shadow_held  = 0;
    shadow_hash  = 64'd0;
    seed_reg     = 64'd0;
    expected_reg = 64'd0;
    mask_reg     = 64'd0;
    add_reg      = 32'd0;
    mul_reg      = 32'd1;
    xor_reg      = 8'd0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_gate_pass();
    test_long_payload();
    test_backpressure();
    test_random_phases(RANDOM_ITEMS);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_hash_gated_stream_decrypt_top: PASS");
    end else begin
      $display("tb_hash_gated_stream_decrypt_top: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
